>>> rtl/tbc_pkg.sv
// Shared codes and widths for the thermostat button controller.
// No dependencies.
package tbc_pkg;

  localparam int unsigned TempW   = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLockoutMs    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSetpointStep = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSetpointMin  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSetpointMax  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSwitchMargin = 3'd4;

  // Operating modes
  localparam logic [1:0] ModeOff  = 2'd0;
  localparam logic [1:0] ModeCool = 2'd1;
  localparam logic [1:0] ModeHeat = 2'd2;

  // Button codes
  localparam logic [1:0] BtnMode  = 2'd0;
  localparam logic [1:0] BtnDown  = 2'd1;
  localparam logic [1:0] BtnUp    = 2'd2;
  localparam logic [1:0] BtnKnown = 2'd3;

  // Item kinds
  localparam logic FuncTick  = 1'b0;
  localparam logic FuncPress = 1'b1;

  // Reset values of configuration and state
  localparam logic [15:0]      LockoutReset  = 16'd300;
  localparam logic [6:0]       StepReset     = 7'd5;
  localparam logic [TempW-1:0] SpMinReset    = 11'sd160;
  localparam logic [TempW-1:0] SpMaxReset    = 11'sd350;
  localparam logic [7:0]       MarginReset   = 8'd10;
  localparam logic [TempW-1:0] SetpointReset = 11'sd220;

endpackage

>>> rtl/thermostat_button_controller_core.sv
// Thermostat with lockout-filtered buttons and on/off cooling and heating demand.
// Depends on tbc_pkg for register indexes, mode and button codes.
// A word is held in the input register, and its result then in the result register.
// Throughput: one word per cycle while out_stall_i stays low; the state update for a word is one pass of logic.
// The input register takes a new word while a result waits to be taken, if it holds no word itself.
// Reset (rst_ni low, asynchronous) restores configuration and state defaults at once.
module thermostat_button_controller_core #(
  parameter int unsigned BUTTON_COUNT = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tbc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tbc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [1:0]                        button_i,
  input  logic [31:0]                       time_ms_i,
  input  logic signed [tbc_pkg::TempW-1:0]  temperature_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              press_accepted_o,
  output logic [1:0]                        mode_o,
  output logic signed [tbc_pkg::TempW-1:0]  setpoint_o,
  output logic                              cooling_on_o,
  output logic                              heating_on_o
);
  import tbc_pkg::*;

  // Only buttons below both the known range and BUTTON_COUNT keep a time stamp
  localparam int unsigned LastDepth = (BUTTON_COUNT < 3) ? BUTTON_COUNT : 3;
  localparam int unsigned IdxW      = (LastDepth > 1) ? $clog2(LastDepth) : 1;

  // Configuration
  logic [15:0]             lockout_q;
  logic [6:0]              step_q;
  logic signed [TempW-1:0] sp_min_q;
  logic signed [TempW-1:0] sp_max_q;
  logic [7:0]              margin_q;

  // Input register
  logic                    in_valid_q;
  logic                    func_q;
  logic [1:0]              button_q;
  logic [31:0]             time_q;
  logic signed [TempW-1:0] temp_q;

  // Controller state
  logic [1:0]              mode_q, mode_d;
  logic signed [TempW-1:0] setpoint_q, setpoint_d;
  logic [31:0]             last_q [LastDepth];
  logic                    cool_q, cool_d;
  logic                    heat_q, heat_d;

  // Result register
  logic                    out_valid_q;
  logic                    acc_q, acc_d;

  logic                    in_fire, out_fire, out_free, advance;
  logic                    known, passed;
  logic [IdxW-1:0]         btn_idx;
  logic [31:0]             elapsed;
  logic signed [TempW:0]   sp_dn, sp_up, cool_thr, heat_thr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  assign known   = (button_q != BtnKnown) && ({30'd0, button_q} < 32'(LastDepth));
  assign btn_idx = button_q[IdxW-1:0];
  assign elapsed = time_q - last_q[btn_idx];
  assign passed  = known && (elapsed >= {16'd0, lockout_q});

  assign sp_dn    = {setpoint_q[TempW-1], setpoint_q} - $signed({5'd0, step_q});
  assign sp_up    = {setpoint_q[TempW-1], setpoint_q} + $signed({5'd0, step_q});
  assign cool_thr = {setpoint_q[TempW-1], setpoint_q} - $signed({4'd0, margin_q});
  assign heat_thr = {setpoint_q[TempW-1], setpoint_q} + $signed({4'd0, margin_q});

  always_comb begin
    mode_d     = mode_q;
    setpoint_d = setpoint_q;
    cool_d     = cool_q;
    heat_d     = heat_q;
    acc_d      = 1'b0;
    if (func_q == FuncPress) begin
      if (passed) begin
        acc_d = 1'b1;
        case (button_q)
          BtnMode: begin
            mode_d = (mode_q >= ModeHeat) ? ModeOff : mode_q + 2'd1;
          end
          BtnDown: begin
            // floor only
            if (sp_dn < $signed({sp_min_q[TempW-1], sp_min_q})) setpoint_d = sp_min_q;
            else setpoint_d = sp_dn[TempW-1:0];
          end
          BtnUp: begin
            // ceiling only
            if (sp_up > $signed({sp_max_q[TempW-1], sp_max_q})) setpoint_d = sp_max_q;
            else setpoint_d = sp_up[TempW-1:0];
          end
          default: begin
            acc_d = 1'b0;
          end
        endcase
      end
    end else begin
      cool_d = (mode_q == ModeCool) && ($signed({temp_q[TempW-1], temp_q}) > cool_thr);
      heat_d = (mode_q == ModeHeat) && ($signed({temp_q[TempW-1], temp_q}) < heat_thr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LockoutReset;
      step_q    <= StepReset;
      sp_min_q  <= SpMinReset;
      sp_max_q  <= SpMaxReset;
      margin_q  <= MarginReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLockoutMs:    lockout_q <= cfg_wdata_i;
        RegSetpointStep: step_q    <= cfg_wdata_i[6:0];
        RegSetpointMin:  sp_min_q  <= cfg_wdata_i[TempW-1:0];
        RegSetpointMax:  sp_max_q  <= cfg_wdata_i[TempW-1:0];
        RegSwitchMargin: margin_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeOff;
      setpoint_q  <= SetpointReset;
      cool_q      <= 1'b0;
      heat_q      <= 1'b0;
      for (int i = 0; i < LastDepth; i++) last_q[i] <= '0;
    end else begin
      if (in_fire) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;

      if (advance) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;

      if (advance) begin
        mode_q     <= mode_d;
        setpoint_q <= setpoint_d;
        cool_q     <= cool_d;
        heat_q     <= heat_d;
        // stamp the time of an accepted press
        if (func_q == FuncPress && passed) begin
          for (int i = 0; i < LastDepth; i++) begin
            if (btn_idx == IdxW'(i)) last_q[i] <= time_q;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= func_i;
      button_q <= button_i;
      time_q   <= time_ms_i;
      temp_q   <= temperature_i;
    end
    if (advance) acc_q <= acc_d;
  end

  assign out_valid_o      = out_valid_q;
  assign press_accepted_o = acc_q;
  assign mode_o           = mode_q;
  assign setpoint_o       = setpoint_q;
  assign cooling_on_o     = cool_q;
  assign heating_on_o     = heat_q;

endmodule

>>> test/thermostat_checker.sv
// Watches both channels and the register port of the thermostat core, keeps its own
// thermostat state and compares every result word with the oldest prediction.
// Depends on tbc_pkg for register indexes, mode, button and item codes.
module thermostat_checker #(
  parameter int unsigned ButtonCount = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tbc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tbc_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               func_i,
  input  logic [1:0]                         button_i,
  input  logic [31:0]                        time_ms_i,
  input  logic signed [tbc_pkg::TempW-1:0]   temperature_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic                               press_accepted_i,
  input  logic [1:0]                         mode_i,
  input  logic signed [tbc_pkg::TempW-1:0]   setpoint_i,
  input  logic                               cooling_on_i,
  input  logic                               heating_on_i,
  output int                                 mismatch_count_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tbc_pkg::*;

  typedef struct {
    logic                    accepted;
    logic [1:0]              mode;
    logic signed [TempW-1:0] setpoint;
    logic                    cooling;
    logic                    heating;
  } status_t;

  status_t     status_q[$];
  int          mismatches = 0;

  // thermostat settings
  logic [15:0] lockout_q;
  logic [6:0]  step_q;
  int          sp_min_q;
  int          sp_max_q;
  int          margin_q;

  // thermostat state
  logic [1:0]  mode_q;
  int          setpoint_q;
  logic [31:0] last_press_q [ButtonCount];
  logic        cooling_q;
  logic        heating_q;

  function automatic status_t advance_thermostat(logic func, logic [1:0] button,
                                                 logic [31:0] now, int temp);
    status_t r;
    int      s;
    r.accepted = 1'b0;
    if (func == FuncPress) begin
      if (button < BtnKnown && button < ButtonCount) begin
        // unsigned wrapping distance from the last accepted press of this button
        if (now - last_press_q[button] >= {16'd0, lockout_q}) begin
          r.accepted = 1'b1;
          last_press_q[button] = now;
          case (button)
            BtnMode: mode_q = (mode_q == ModeOff)  ? ModeCool :
                              (mode_q == ModeCool) ? ModeHeat : ModeOff;
            BtnDown: begin
              s = setpoint_q - int'(step_q);
              setpoint_q = (s < sp_min_q) ? sp_min_q : s;
            end
            default: begin
              s = setpoint_q + int'(step_q);
              setpoint_q = (s > sp_max_q) ? sp_max_q : s;
            end
          endcase
        end
      end
    end else begin
      cooling_q = (mode_q == ModeCool) && (temp > setpoint_q - margin_q);
      heating_q = (mode_q == ModeHeat) && (temp < setpoint_q + margin_q);
    end
    r.mode     = mode_q;
    r.setpoint = setpoint_q[TempW-1:0];
    r.cooling  = cooling_q;
    r.heating  = heating_q;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    status_t want;
    if (!rst_ni) begin
      lockout_q  = LockoutReset;
      step_q     = StepReset;
      sp_min_q   = int'($signed(SpMinReset));
      sp_max_q   = int'($signed(SpMaxReset));
      margin_q   = int'(MarginReset);
      mode_q     = ModeOff;
      setpoint_q = int'($signed(SetpointReset));
      for (int i = 0; i < ButtonCount; i++) last_press_q[i] = '0;
      cooling_q  = 1'b0;
      heating_q  = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegLockoutMs:    lockout_q = cfg_wdata_i[15:0];
          RegSetpointStep: step_q    = cfg_wdata_i[6:0];
          RegSetpointMin:  sp_min_q  = int'($signed(cfg_wdata_i[TempW-1:0]));
          RegSetpointMax:  sp_max_q  = int'($signed(cfg_wdata_i[TempW-1:0]));
          RegSwitchMargin: margin_q  = int'(cfg_wdata_i[7:0]);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("press_accepted", want.accepted, press_accepted_i);
          check_field("mode", want.mode, mode_i);
          check_field("setpoint", want.setpoint, setpoint_i);
          check_field("cooling_on", want.cooling, cooling_on_i);
          check_field("heating_on", want.heating, heating_on_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        status_q.push_back(advance_thermostat(func_i, button_i, time_ms_i, temperature_i));
    end
    pending_o        <= status_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

>>> test/thermostat_button_controller_core_tb.sv
// Drives presses, ticks and register writes into the thermostat core and gives the verdict.
// Depends on tbc_pkg, thermostat_button_controller_core and thermostat_checker.
module thermostat_button_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbc_pkg::*;

  localparam int CycleLimit  = 200_000;
  localparam int PhaseWords  = 230;
  localparam int PhaseCount  = 8;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [CfgDataW-1:0]     cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    func_i;
  logic [1:0]              button_i;
  logic [31:0]             time_ms_i;
  logic signed [TempW-1:0] temperature_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    press_accepted_o;
  logic [1:0]              mode_o;
  logic signed [TempW-1:0] setpoint_o;
  logic                    cooling_on_o;
  logic                    heating_on_o;

  int          mismatches;
  int          pending_words;
  int          cycles = 0;
  logic        no_idle = 1'b0;
  logic [31:0] now_ms = '0;
  int          lockout_now = 300;
  int          margin_now = 10;
  int          last_sp = 220;

  thermostat_button_controller_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .func_i, .button_i, .time_ms_i, .temperature_i,
    .out_valid_o, .out_stall_i, .press_accepted_o, .mode_o, .setpoint_o,
    .cooling_on_o, .heating_on_o
  );

  thermostat_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .button_i, .time_ms_i,
    .temperature_i, .out_valid_i(out_valid_o), .out_stall_i,
    .press_accepted_i(press_accepted_o), .mode_i(mode_o), .setpoint_i(setpoint_o),
    .cooling_on_i(cooling_on_o), .heating_on_i(heating_on_o),
    .mismatch_count_o(mismatches), .pending_o(pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // track the reported setpoint so ticks can aim at the switching thresholds
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) last_sp <= int'(setpoint_o);
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !no_idle && ($urandom_range(99) < 29);
    end
  end

  task automatic send_word(logic func, logic [1:0] button, logic [31:0] stamp, int temp);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    button_i      <= button;
    time_ms_i     <= stamp;
    temperature_i <= temp[TempW-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // unused fields of a word carry random noise
  task automatic press(logic [1:0] button, logic [31:0] stamp);
    send_word(FuncPress, button, stamp, int'($urandom_range(0, 1200)) - 400);
  endtask

  task automatic tick(int temp);
    send_word(FuncTick, 2'($urandom()), $urandom(), temp);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic write_settings(int lockout, int step, int sp_min, int sp_max, int margin);
    drain();
    put_reg(RegLockoutMs, 16'(lockout));
    put_reg(RegSetpointStep, 16'(step));
    put_reg(RegSetpointMin, 16'(sp_min));
    put_reg(RegSetpointMax, 16'(sp_max));
    put_reg(RegSwitchMargin, 16'(margin));
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    lockout_now = lockout;
    margin_now  = margin;
  endtask

  task automatic random_settings();
    int r;
    int lo;
    int hi;
    int t;
    r  = $urandom_range(99);
    lo = int'($urandom_range(0, 1200)) - 400;
    hi = int'($urandom_range(0, 1200)) - 400;
    // keep the range ordered most of the time
    if (lo > hi && $urandom_range(99) < 80) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    write_settings(r < 15 ? 0 : r < 25 ? 65535 : int'($urandom_range(0, 1000)),
                   $urandom_range(1, 100), lo, hi, $urandom_range(0, 200));
  endtask

  task automatic random_word();
    int          r;
    int          temp;
    logic [1:0]  b;
    if ($urandom_range(99) < 45) begin
      if ($urandom_range(1)) begin
        temp = last_sp + ($urandom_range(1) ? margin_now : -margin_now)
               + int'($urandom_range(0, 4)) - 2;
        if (temp < -400) temp = -400;
        if (temp > 800) temp = 800;
      end else begin
        temp = int'($urandom_range(0, 1200)) - 400;
      end
      tick(temp);
    end else begin
      r = $urandom_range(99);
      b = r < 8 ? BtnKnown : r < 36 ? BtnMode : r < 68 ? BtnDown : BtnUp;
      r = $urandom_range(99);
      if (r < 8)
        now_ms = $urandom();
      else if (r < 20)
        now_ms = now_ms + lockout_now - int'($urandom_range(0, 1));
      else
        now_ms = now_ms + $urandom_range(0, 2 * lockout_now + 20);
      press(b, now_ms);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = RegLockoutMs;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    func_i        = FuncTick;
    button_i      = BtnMode;
    time_ms_i     = '0;
    temperature_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // settings as after reset
    tick(-400);
    press(BtnUp, 32'd0);              // stored times start at zero: locked out
    press(BtnKnown, 32'd1000);
    press(BtnMode, 32'd1000);         // off to cool
    tick(800);
    tick(210);                        // exactly setpoint minus margin: cooling drops
    press(BtnDown, 32'd1000);
    press(BtnDown, 32'd1299);
    press(BtnMode, 32'd1299);         // one short of the lockout
    press(BtnMode, 32'd1300);         // cool to heat, demands held from last tick
    tick(224);
    tick(225);                        // exactly setpoint plus margin: heating drops
    press(BtnMode, 32'hFFFF_FFFF);    // heat back to off
    press(BtnUp, 32'hFFFF_FFFF);
    press(BtnUp, 32'h0000_012A);      // wrapped distance 299
    press(BtnUp, 32'h0000_012B);      // wrapped distance 300

    write_settings(0, 100, -400, 800, 200);
    repeat (6) press(BtnUp, 32'd5);   // no lockout, clamp at the ceiling
    press(BtnMode, 32'd5);
    tick(800);

    // inverted range: setpoint moves to the crossed bound in one step
    write_settings(65535, 100, 800, -400, 0);
    press(BtnDown, 32'h8000_0000);
    press(BtnUp, 32'h8000_0000);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: write_settings(0, 1, -400, 800, 0);
        1: write_settings(65535, 100, 800, -400, 200);
        default: random_settings();
      endcase
      no_idle = (p == 3);
      for (int n = 0; n < PhaseWords; n++) random_word();
    end
    no_idle = 1'b0;

    drain();
    if (mismatches == 0 && pending_words == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
